// File: rtl/drtq_pkg.sv
// drtq_pkg: shared types, constants and command codes for the delayed/ready task queues.
// No dependencies.
package drtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int TASK_WIDTH_DEF  = 8;

  typedef enum logic [1:0] {
    FUNC_ADD_READY   = 2'd0,
    FUNC_ADD_DELAYED = 2'd1,
    FUNC_DEQUEUE     = 2'd2,
    FUNC_TICK        = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  task_id;
    logic [15:0] priority_req;
    logic [15:0] delay;
    logic [15:0] tick_count;
  } request_t;

  typedef struct packed {
    logic [7:0] out_task;
    logic       out_valid;
    logic [1:0] status;
    logic       ready_empty;
    logic [4:0] moved_count;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture request fields
    logic r_ins_step;  // one shift step of a ready insert
    logic r_ins_done;  // final write and count increment
    logic d_ins_step;
    logic d_ins_done;
    logic r_pop_step;  // one shift step of a ready pop
    logic r_pop_done;
    logic d_pop_step;
    logic d_pop_done;
    logic dec_step;    // saturating subtract on one delayed entry
    logic move_load;   // take delayed head as the ready insert operand
    logic clr_idx;     // reset walk index to zero
    logic set_idx_r;   // index := ready count
    logic set_idx_d;   // index := delay count
    logic inc_idx;
  } ctrl_t;

  typedef struct packed {
    logic r_full;
    logic r_zero;
    logic d_full;
    logic d_zero;
    logic r_ins_here;  // insert slot for ready found at index
    logic d_ins_here;
    logic r_pop_end;   // pop walk reached last entry
    logic d_pop_end;
    logic dec_end;     // decrement walk passed last entry
    logic d_head_zero; // delayed head has zero delay
  } stat_t;

endpackage

// File: rtl/drtq_ctrl.sv
// drtq_ctrl: command sequencer for the task queues.
// Depends on drtq_pkg.
module drtq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          func,
  input  drtq_pkg::stat_t     st,
  output drtq_pkg::ctrl_t     cmd,
  output logic                busy,
  output logic                done,
  output logic                deq_ok,
  output drtq_pkg::status_t   status,
  output logic [4:0]          moved
);
  import drtq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RINS, S_DINS, S_RPOP, S_DEC, S_CHK, S_MVINS, S_MVPOP, S_DONE
  } state_t;

  state_t state;
  func_t  f;     // request code, held for the whole request

  always_comb begin
    cmd = '0;
    if (state == S_IDLE && start) begin
      cmd.load = 1'b1;
    end
    unique case (state)
      S_IDLE: ;
      S_DECODE: begin
        if (f == FUNC_TICK) cmd.clr_idx = 1'b1;
        else if (f == FUNC_ADD_DELAYED) cmd.set_idx_d = 1'b1;
        else if (f == FUNC_DEQUEUE) cmd.clr_idx = 1'b1;
        else cmd.set_idx_r = 1'b1;
      end
      S_RINS: begin
        if (st.r_ins_here) cmd.r_ins_done = 1'b1;
        else cmd.r_ins_step = 1'b1;
      end
      S_DINS: begin
        if (st.d_ins_here) cmd.d_ins_done = 1'b1;
        else cmd.d_ins_step = 1'b1;
      end
      S_RPOP: begin
        if (st.r_pop_end) cmd.r_pop_done = 1'b1;
        else cmd.r_pop_step = 1'b1;
      end
      S_DEC: begin
        if (!st.dec_end) cmd.dec_step = 1'b1;
      end
      S_CHK: begin
        if (!st.d_zero && st.d_head_zero && !st.r_full) begin
          cmd.move_load = 1'b1;
          cmd.set_idx_r = 1'b1;
        end
      end
      S_MVINS: begin
        // delayed pop walk starts from the head
        if (st.r_ins_here) begin
          cmd.r_ins_done = 1'b1;
          cmd.clr_idx    = 1'b1;
        end else cmd.r_ins_step = 1'b1;
      end
      S_MVPOP: begin
        if (st.d_pop_end) cmd.d_pop_done = 1'b1;
        else cmd.d_pop_step = 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
    if (state == S_DEC && !st.dec_end) cmd.inc_idx = 1'b1;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      f      <= FUNC_ADD_READY;
      done   <= 1'b0;
      deq_ok <= 1'b0;
      status <= ST_OK;
      moved  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state  <= S_DECODE;
            f      <= func_t'(func);
            deq_ok <= 1'b0;
            status <= ST_OK;
            moved  <= '0;
          end
        end
        S_DECODE: begin
          unique case (f)
            FUNC_ADD_READY: begin
              if (st.r_full) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else state <= S_RINS;
            end
            FUNC_ADD_DELAYED: begin
              if (st.d_full) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else state <= S_DINS;
            end
            FUNC_DEQUEUE: begin
              if (st.r_zero) begin
                status <= ST_EMPTY;
                state  <= S_DONE;
              end else begin
                deq_ok <= 1'b1;
                state  <= S_RPOP;
              end
            end
            FUNC_TICK: state <= S_DEC;
            default: state <= S_DONE;
          endcase
        end
        S_RINS:  if (st.r_ins_here) state <= S_DONE;
        S_DINS:  if (st.d_ins_here) state <= S_DONE;
        S_RPOP:  if (st.r_pop_end) state <= S_DONE;
        S_DEC:   if (st.dec_end) state <= S_CHK;
        S_CHK: begin
          if (!st.d_zero && st.d_head_zero) begin
            if (st.r_full) begin
              status <= ST_FULL;
              state  <= S_DONE;
            end else state <= S_MVINS;
          end else state <= S_DONE;
        end
        S_MVINS: if (st.r_ins_here) state <= S_MVPOP;
        S_MVPOP: begin
          if (st.d_pop_end) begin
            moved <= moved + 5'd1;
            state <= S_CHK;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/drtq_dp.sv
// drtq_dp: task tables, walk index and operand registers.
// Depends on drtq_pkg.
module drtq_dp #(
  parameter int QUEUE_DEPTH = drtq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_WIDTH   = drtq_pkg::KEY_WIDTH_DEF,
  parameter int TASK_WIDTH  = drtq_pkg::TASK_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  drtq_pkg::request_t req,
  input  drtq_pkg::ctrl_t   cmd,
  output drtq_pkg::stat_t   st,
  output logic [TASK_WIDTH-1:0] head_task,
  output logic              ready_empty
);
  import drtq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [KEY_WIDTH-1:0]  r_prio [QUEUE_DEPTH];
  logic [TASK_WIDTH-1:0] r_task [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0]  d_left [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0]  d_prio [QUEUE_DEPTH];
  logic [TASK_WIDTH-1:0] d_task [QUEUE_DEPTH];
  logic [CW-1:0] r_cnt, d_cnt, idx;

  // operand registers
  logic [KEY_WIDTH-1:0]  op_prio, op_left, op_ticks;
  logic [TASK_WIDTH-1:0] op_task;

  logic [IW-1:0] ix, ixm1, ixp1;
  logic          idx_nz;

  assign ix     = idx[IW-1:0];
  assign ixm1   = ix - IW'(1);
  assign ixp1   = ix + IW'(1);
  assign idx_nz = (idx != '0);

  assign st.r_full     = (r_cnt == CW'(QUEUE_DEPTH));
  assign st.d_full     = (d_cnt == CW'(QUEUE_DEPTH));
  assign st.r_zero     = (r_cnt == '0);
  assign st.d_zero     = (d_cnt == '0);
  // walking down from count: stop where predecessor key <= new key
  assign st.r_ins_here = !idx_nz || (r_prio[ixm1] <= op_prio);
  assign st.d_ins_here = !idx_nz || (d_left[ixm1] <= op_left);
  assign st.r_pop_end  = ((idx + CW'(1)) >= r_cnt);
  assign st.d_pop_end  = ((idx + CW'(1)) >= d_cnt);
  assign st.dec_end    = (idx >= d_cnt);
  assign st.d_head_zero = (d_left[0] == '0);

  assign head_task   = r_task[0];
  assign ready_empty = (r_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt <= '0;
      d_cnt <= '0;
      idx   <= '0;
    end else begin
      if (cmd.clr_idx) idx <= '0;
      if (cmd.set_idx_r) idx <= r_cnt;
      if (cmd.set_idx_d) idx <= d_cnt;
      if (cmd.inc_idx) idx <= idx + CW'(1);
      if (cmd.r_ins_step || cmd.d_ins_step) idx <= idx - CW'(1);
      if (cmd.r_pop_step || cmd.d_pop_step) idx <= idx + CW'(1);
      if (cmd.r_ins_done) r_cnt <= r_cnt + CW'(1);
      if (cmd.d_ins_done) d_cnt <= d_cnt + CW'(1);
      if (cmd.r_pop_done) begin
        r_cnt <= r_cnt - CW'(1);
        idx   <= '0;
      end
      if (cmd.d_pop_done) begin
        d_cnt <= d_cnt - CW'(1);
        idx   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_task  <= req.task_id[TASK_WIDTH-1:0];
      op_prio  <= KEY_WIDTH'(req.priority_req);
      op_left  <= KEY_WIDTH'(req.delay);
      op_ticks <= KEY_WIDTH'(req.tick_count);
    end
    if (cmd.move_load) begin
      op_prio <= d_prio[0];
      op_task <= d_task[0];
    end
    if (cmd.r_ins_step) begin
      r_prio[ix] <= r_prio[ixm1];
      r_task[ix] <= r_task[ixm1];
    end
    if (cmd.r_ins_done) begin
      r_prio[ix] <= op_prio;
      r_task[ix] <= op_task;
    end
    if (cmd.d_ins_step) begin
      d_left[ix] <= d_left[ixm1];
      d_prio[ix] <= d_prio[ixm1];
      d_task[ix] <= d_task[ixm1];
    end
    if (cmd.d_ins_done) begin
      d_left[ix] <= op_left;
      d_prio[ix] <= op_prio;
      d_task[ix] <= op_task;
    end
    if (cmd.r_pop_step) begin
      r_prio[ix] <= r_prio[ixp1];
      r_task[ix] <= r_task[ixp1];
    end
    if (cmd.d_pop_step) begin
      d_left[ix] <= d_left[ixp1];
      d_prio[ix] <= d_prio[ixp1];
      d_task[ix] <= d_task[ixp1];
    end
    if (cmd.dec_step) begin
      d_left[ix] <= (d_left[ix] > op_ticks) ? d_left[ix] - op_ticks : '0;
    end
  end
endmodule

// File: rtl/delayed_ready_task_queues.sv
// delayed_ready_task_queues: top level joining sequencer and datapath.
// Depends on drtq_pkg, drtq_ctrl, drtq_dp.
//
// Usage:
//   A request is taken when start is high and busy is low; all request
//   fields are captured then, so the sender may change them while busy.
//   Exactly one result follows, shown for one cycle with done high; the
//   receiver cannot stall it. busy drops in the done cycle.
//   Requests: add ready, add delayed (sorted insert, ties behind equals),
//   dequeue ready head, tick (saturating decrement of every delay, then
//   move zero-delay heads into the ready table while it has room).
//   Every insert or pop step moves one table entry. For each moved entry,
//   a tick runs an insert walk over the ready entries, a pop walk over the
//   delayed entries and a head check. Rejected adds and empty dequeues skip
//   the walks.
//   Reset clears both counts; table contents need no clearing.
module delayed_ready_task_queues #(
  parameter int QUEUE_DEPTH = drtq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_WIDTH   = drtq_pkg::KEY_WIDTH_DEF,
  parameter int TASK_WIDTH  = drtq_pkg::TASK_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  drtq_pkg::request_t request,
  output logic               done,
  output drtq_pkg::result_t  result
);
  import drtq_pkg::*;

  ctrl_t   cmd;
  stat_t   st;
  status_t status;
  logic    deq_ok, ready_empty;
  logic [4:0] moved;
  logic [TASK_WIDTH-1:0] head_task;
  logic [TASK_WIDTH-1:0] taken_task;

  drtq_ctrl u_ctrl (
    .clk, .rst, .start, .func(request.func), .st, .cmd, .busy, .done,
    .deq_ok, .status, .moved
  );

  drtq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .KEY_WIDTH(KEY_WIDTH), .TASK_WIDTH(TASK_WIDTH)) u_dp (
    .clk, .rst, .req(request), .cmd, .st, .head_task, .ready_empty
  );

  // head is captured before the pop walk overwrites it
  always_ff @(posedge clk) begin
    if (cmd.load) taken_task <= head_task;
  end

  always_comb begin
    result             = '0;
    result.out_task    = deq_ok ? 8'(taken_task) : 8'd0;
    result.out_valid   = deq_ok;
    result.status      = status;
    result.ready_empty = ready_empty;
    result.moved_count = moved;
  end
endmodule

// File: dv/delayed_ready_task_queues_tb.sv
// Self-checking testbench for delayed_ready_task_queues: directed table, then random
// scheduler traffic, checked against a behavioural model of both sorted tables.
// Depends on drtq_pkg and the delayed_ready_task_queues RTL.
module delayed_ready_task_queues_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drtq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  delayed_ready_task_queues i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Model of the two tables; only entries below the counts matter.
  logic [15:0] rdy_prio [DEPTH];
  logic [7:0]  rdy_task [DEPTH];
  int          rdy_cnt;
  logic [15:0] dly_left [DEPTH];
  logic [15:0] dly_prio [DEPTH];
  logic [7:0]  dly_task [DEPTH];
  int          dly_cnt;

  result_t pending_results[$];
  int      mismatches;
  int      cycles;
  bit      timed_out;

  // Sorted insert, ties go behind equal keys.
  function automatic void rdy_put(logic [15:0] p, logic [7:0] t);
    int pos;
    pos = 0;
    while (pos < rdy_cnt && rdy_prio[pos] <= p) pos++;
    for (int i = rdy_cnt; i > pos; i--) begin
      rdy_prio[i] = rdy_prio[i-1];
      rdy_task[i] = rdy_task[i-1];
    end
    rdy_prio[pos] = p;
    rdy_task[pos] = t;
    rdy_cnt++;
  endfunction

  function automatic result_t schedule_step(request_t rq);
    result_t r;
    int pos;
    r = '0;
    case (func_t'(rq.func))
      FUNC_ADD_READY: begin
        if (rdy_cnt >= DEPTH) r.status = ST_FULL;
        else rdy_put(rq.priority_req, rq.task_id);
      end
      FUNC_ADD_DELAYED: begin
        if (dly_cnt >= DEPTH) r.status = ST_FULL;
        else begin
          pos = 0;
          while (pos < dly_cnt && dly_left[pos] <= rq.delay) pos++;
          for (int i = dly_cnt; i > pos; i--) begin
            dly_left[i] = dly_left[i-1];
            dly_prio[i] = dly_prio[i-1];
            dly_task[i] = dly_task[i-1];
          end
          dly_left[pos] = rq.delay;
          dly_prio[pos] = rq.priority_req;
          dly_task[pos] = rq.task_id;
          dly_cnt++;
        end
      end
      FUNC_DEQUEUE: begin
        if (rdy_cnt == 0) r.status = ST_EMPTY;
        else begin
          r.out_task  = rdy_task[0];
          r.out_valid = 1'b1;
          for (int i = 1; i < rdy_cnt; i++) begin
            rdy_prio[i-1] = rdy_prio[i];
            rdy_task[i-1] = rdy_task[i];
          end
          rdy_cnt--;
        end
      end
      default: begin
        // saturating decrement, then move zero heads while there is room
        for (int i = 0; i < dly_cnt; i++)
          dly_left[i] = (dly_left[i] > rq.tick_count) ? dly_left[i] - rq.tick_count : '0;
        while (dly_cnt > 0 && dly_left[0] == 0) begin
          if (rdy_cnt >= DEPTH) begin
            r.status = ST_FULL;
            break;
          end
          rdy_put(dly_prio[0], dly_task[0]);
          for (int i = 1; i < dly_cnt; i++) begin
            dly_left[i-1] = dly_left[i];
            dly_prio[i-1] = dly_prio[i];
            dly_task[i-1] = dly_task[i];
          end
          dly_cnt--;
          r.moved_count++;
        end
      end
    endcase
    r.ready_empty = (rdy_cnt == 0);
    return r;
  endfunction

  // Directed table: func, task, prio, delay, ticks, check flag, typed result.
  typedef struct {
    func_t       f;
    logic [7:0]  t;
    logic [15:0] p;
    logic [15:0] d;
    logic [15:0] k;
    bit          typed;
    result_t     want;
  } row_t;

  row_t plan[$];

  function automatic row_t mk(func_t f, logic [7:0] t, logic [15:0] p, logic [15:0] d,
                              logic [15:0] k, bit typed = 0, result_t want = '0);
    row_t x;
    x.f = f; x.t = t; x.p = p; x.d = d; x.k = k; x.typed = typed; x.want = want;
    return x;
  endfunction

  function automatic result_t res(logic [7:0] t, logic v, status_t s, logic e, logic [4:0] m);
    result_t r;
    r.out_task = t; r.out_valid = v; r.status = s; r.ready_empty = e; r.moved_count = m;
    return r;
  endfunction

  // Results come out one cycle wide; compare with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        e = pending_results.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, result);
        end
      end
    end
  end

  int send_idle_pct;

  // One request: optional idle gap, present at falling edge, wait for acceptance.
  // start stays high after acceptance; the next call or the caller drops it.
  task automatic issue(request_t rq, bit typed, result_t want);
    result_t e;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    request <= rq;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    e = schedule_step(rq);
    if (typed && e !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", want, e);
    end
    pending_results.push_back(e);
  endtask

  function automatic request_t rand_req(int phase);
    request_t rq;
    int sel;
    rq.task_id      = $urandom;
    rq.tick_count   = $urandom;
    rq.priority_req = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
    rq.delay        = ($urandom_range(3) == 0) ? $urandom : $urandom_range(6);
    if ($urandom_range(9) == 0) rq.tick_count = $urandom;
    else rq.tick_count = $urandom_range(3);
    // bias towards filling or draining so both tables see full and empty
    sel = $urandom_range(99);
    if (phase % 2 == 0) rq.func = (sel < 35) ? FUNC_ADD_READY : (sel < 70) ? FUNC_ADD_DELAYED
                                  : (sel < 85) ? FUNC_DEQUEUE : FUNC_TICK;
    else rq.func = (sel < 15) ? FUNC_ADD_READY : (sel < 30) ? FUNC_ADD_DELAYED
                   : (sel < 70) ? FUNC_DEQUEUE : FUNC_TICK;
    return rq;
  endfunction

  initial begin
    request_t rq;
    rst = 1'b1; start = 1'b0; request = '0;
    mismatches = 0; cycles = 0; timed_out = 0; send_idle_pct = 13;
    rdy_cnt = 0; dly_cnt = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty dequeue and tick on empty tables, then ready adds with a tie, dequeues and delayed ticks
    plan.push_back(mk(FUNC_DEQUEUE, 8'h00, 0, 0, 0, 1, res(0, 0, ST_EMPTY, 1, 0)));
    plan.push_back(mk(FUNC_TICK, 8'h00, 0, 0, 16'hffff, 1, res(0, 0, ST_OK, 1, 0)));
    plan.push_back(mk(FUNC_ADD_READY, 8'hff, 16'hffff, 0, 0, 1, res(0, 0, ST_OK, 0, 0)));
    plan.push_back(mk(FUNC_ADD_READY, 8'h00, 16'h0000, 0, 0));
    plan.push_back(mk(FUNC_ADD_READY, 8'h5a, 16'hffff, 0, 0));   // tie behind equal key
    plan.push_back(mk(FUNC_DEQUEUE, 0, 0, 0, 0, 1, res(8'h00, 1, ST_OK, 0, 0)));
    plan.push_back(mk(FUNC_DEQUEUE, 0, 0, 0, 0, 1, res(8'hff, 1, ST_OK, 0, 0)));
    plan.push_back(mk(FUNC_DEQUEUE, 0, 0, 0, 0, 1, res(8'h5a, 1, ST_OK, 1, 0)));
    plan.push_back(mk(FUNC_ADD_DELAYED, 8'h11, 16'h0003, 16'h0000, 0)); // zero delay waits
    plan.push_back(mk(FUNC_ADD_DELAYED, 8'h22, 16'h0001, 16'hffff, 0));
    plan.push_back(mk(FUNC_ADD_DELAYED, 8'h33, 16'h0002, 16'h0005, 0));
    plan.push_back(mk(FUNC_TICK, 0, 0, 0, 16'h0000, 1, res(0, 0, ST_OK, 0, 1)));
    plan.push_back(mk(FUNC_TICK, 0, 0, 0, 16'h0009, 1, res(0, 0, ST_OK, 0, 1))); // saturates
    plan.push_back(mk(FUNC_TICK, 0, 0, 0, 16'hffff, 1, res(0, 0, ST_OK, 0, 1)));
    for (int i = 0; i < 3; i++) plan.push_back(mk(FUNC_DEQUEUE, 0, 0, 0, 0));
    foreach (plan[i]) begin
      rq = '0;
      rq.func = plan[i].f; rq.task_id = plan[i].t; rq.priority_req = plan[i].p;
      rq.delay = plan[i].d; rq.tick_count = plan[i].k;
      issue(rq, plan[i].typed, plan[i].want);
    end

    // fill the ready table, overflow it, then fill delayed and tick into a full ready table
    for (int i = 0; i < DEPTH + 1; i++) begin
      rq = '0; rq.func = FUNC_ADD_READY; rq.task_id = $urandom; rq.priority_req = $urandom_range(3);
      issue(rq, 0, '0);
    end
    for (int i = 0; i < DEPTH + 1; i++) begin
      rq = '0; rq.func = FUNC_ADD_DELAYED; rq.task_id = $urandom; rq.delay = $urandom_range(2);
      issue(rq, 0, '0);
    end
    rq = '0; rq.func = FUNC_TICK; rq.tick_count = 16'h0002;
    issue(rq, 0, '0);
    @(negedge clk);
    start <= 1'b0;

    // hold off until every expected result is in
    while (pending_results.size() != 0) @(negedge clk);

    for (int n = 0; n < 1350; n++) begin
      if (n == 450) send_idle_pct = 50;
      if (n == 900) send_idle_pct = 0;
      issue(rand_req(n / 60), 0, '0);
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (mismatches == 0 && !timed_out) begin
      $display("[delayed_ready_task_queues] OK");
    end else begin
      $display("[delayed_ready_task_queues] ERROR");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[delayed_ready_task_queues] ERROR");
      $finish;
    end
  end
endmodule
